>>> hdl/scs1a_pkg.sv
`timescale 1ns / 1ps

package scs1a_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;

  localparam logic [6:0] CODE_LSHIFT = 7'h2A;
  localparam logic [6:0] CODE_RSHIFT = 7'h36;
  localparam logic [6:0] CODE_CTRL   = 7'h1D;
  localparam logic [6:0] CODE_ALT    = 7'h38;
  localparam logic [6:0] CODE_CAPS   = 7'h3A;
  localparam logic [6:0] CODE_NUM    = 7'h45;
  localparam logic [6:0] CODE_SCROLL = 7'h46;
  localparam logic [6:0] CODE_LAST_CHAR = 7'h3F;

  localparam int unsigned MOD_W = 9;

  localparam int unsigned M_LSHIFT = 0;
  localparam int unsigned M_RSHIFT = 1;
  localparam int unsigned M_LCTRL  = 2;
  localparam int unsigned M_RCTRL  = 3;
  localparam int unsigned M_LALT   = 4;
  localparam int unsigned M_RALT   = 5;
  localparam int unsigned M_CAPS   = 6;
  localparam int unsigned M_NUM    = 7;
  localparam int unsigned M_SCROLL = 8;

  localparam logic [6:0] CHAR_LOW_A = 7'h61;
  localparam logic [6:0] CHAR_LOW_Z = 7'h7A;
  localparam logic [6:0] CHAR_UP_A  = 7'h41;
  localparam logic [6:0] CHAR_UP_Z  = 7'h5A;

  localparam logic [6:0] PLAIN_MAP [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] UPPER_MAP [64] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef struct packed {
    logic [6:0]       key_code;
    logic             is_release;
    logic             ext_flag;
    logic [MOD_W-1:0] modifier_snapshot;
    logic [6:0]       ascii_char;
    logic             led_write;
    logic [2:0]       led_value;
  } event_t;

endpackage

>>> hdl/scs1a_if.sv
`timescale 1ns / 1ps

interface scs1a_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

interface scs1a_event_if;
  logic       valid;
  logic       ready;
  logic [6:0] key_code;
  logic       is_release;
  logic       ext_flag;
  logic [8:0] modifier_snapshot;
  logic [6:0] ascii_char;
  logic       led_write;
  logic [2:0] led_value;

  modport source (
    output valid, output key_code, output is_release, output ext_flag,
    output modifier_snapshot, output ascii_char, output led_write, output led_value,
    input ready
  );
  modport sink (
    input valid, input key_code, input is_release, input ext_flag,
    input modifier_snapshot, input ascii_char, input led_write, input led_value,
    output ready
  );
endinterface

>>> hdl/scancode_set1_to_ascii.sv
`timescale 1ns / 1ps

// PS/2 set-1 scancode decoder.
// scan_i carries raw keyboard bytes; event_o carries one decoded key event
// per byte, except the 0xE0 prefix, which only marks the next byte extended.
// Both channels use valid/ready; an item moves when both are high.
// Each byte is registered in the input register at acceptance, then decoded
// against the modifier state once the event register is free; the event is
// registered there and shown on event_o. Throughput is one byte per cycle
// while event_o is not stalled, set by the input register and the event
// register, with two table lookups and a flag update between them.
// The modifier state updates as each non-prefix byte leaves the input register, so
// events always reflect the byte order.
// While event_o is stalled the event register holds; the input register
// still drains prefix bytes, and scan_i ready drops once a decoded byte is
// waiting behind the held event.
// Reset clears the extended flag, all modifier and lock bits, and both
// valid flags.
module scancode_set1_to_ascii (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  scs1a_byte_if.sink           scan_i,
  scs1a_event_if.source        event_o
);

  logic                          in_valid_q;
  logic [7:0]                    in_byte_q;
  logic                          ext_q;
  logic [scs1a_pkg::MOD_W-1:0]   mods_q;
  logic [scs1a_pkg::MOD_W-1:0]   mods_d;
  logic                          out_valid_q;
  scs1a_pkg::event_t             evt_d;
  scs1a_pkg::event_t             evt_q;

  logic in_is_prefix;
  logic out_free;
  logic s1_fire;
  logic in_ready;

  assign in_is_prefix = (in_byte_q == scs1a_pkg::PREFIX_BYTE);
  assign out_free     = !out_valid_q || event_o.ready;
  assign s1_fire      = in_valid_q && (in_is_prefix || out_free);
  assign in_ready     = !in_valid_q || s1_fire;
  assign scan_i.ready = in_ready;

  scs1a_decode u_decode (
    .scan_byte_i (in_byte_q),
    .ext_i       (ext_q),
    .mods_i      (mods_q),
    .event_o     (evt_d),
    .mods_o      (mods_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      ext_q       <= 1'b0;
      mods_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= scan_i.valid;
      end
      if (s1_fire) begin
        if (in_is_prefix) begin
          ext_q <= 1'b1;
        end else begin
          ext_q  <= 1'b0;
          mods_q <= mods_d;
        end
      end
      if (s1_fire && !in_is_prefix) begin
        out_valid_q <= 1'b1;
      end else if (event_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && scan_i.valid) begin
      in_byte_q <= scan_i.scan_byte;
    end
    if (s1_fire && !in_is_prefix) begin
      evt_q <= evt_d;
    end
  end

  assign event_o.valid             = out_valid_q;
  assign event_o.key_code          = evt_q.key_code;
  assign event_o.is_release        = evt_q.is_release;
  assign event_o.ext_flag          = evt_q.ext_flag;
  assign event_o.modifier_snapshot = evt_q.modifier_snapshot;
  assign event_o.ascii_char        = evt_q.ascii_char;
  assign event_o.led_write         = evt_q.led_write;
  assign event_o.led_value         = evt_q.led_value;

`ifndef SYNTH
  a_led_on_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && evt_q.led_write |->
      (evt_q.key_code == scs1a_pkg::CODE_CAPS) ||
      (evt_q.key_code == scs1a_pkg::CODE_NUM) ||
      (evt_q.key_code == scs1a_pkg::CODE_SCROLL))
    else $error("led write on a non-lock key");

  a_ascii_press_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (evt_q.ascii_char != 7'h00) |->
      !evt_q.is_release && !evt_q.ext_flag)
    else $error("ascii given on release or extended key");

  a_led_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !in_is_prefix |=>
      evt_q.led_value == {mods_q[scs1a_pkg::M_CAPS], mods_q[scs1a_pkg::M_NUM],
                          mods_q[scs1a_pkg::M_SCROLL]})
    else $error("led value differs from lock state");

  a_ext_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !in_is_prefix |=> !ext_q)
    else $error("extended flag not cleared after a key item");
`endif

endmodule

>>> hdl/scs1a_decode.sv
`timescale 1ns / 1ps

module scs1a_decode (
  input  logic [7:0]                    scan_byte_i,
  input  logic                          ext_i,
  input  logic [scs1a_pkg::MOD_W-1:0]   mods_i,
  output scs1a_pkg::event_t             event_o,
  output logic [scs1a_pkg::MOD_W-1:0]   mods_o
);

  logic [6:0] code;
  logic       rel;
  logic       led;
  logic [5:0] idx;
  logic [6:0] base;
  logic [6:0] upper;
  logic       shift;
  logic [6:0] ascii;

  assign code = scan_byte_i[6:0];
  assign rel  = scan_byte_i[7];
  assign idx  = code[5:0];

  always_comb begin
    mods_o = mods_i;
    led    = 1'b0;
    case (code)
      scs1a_pkg::CODE_LSHIFT: mods_o[scs1a_pkg::M_LSHIFT] = !rel;
      scs1a_pkg::CODE_RSHIFT: mods_o[scs1a_pkg::M_RSHIFT] = !rel;
      scs1a_pkg::CODE_CTRL: begin
        if (ext_i) begin
          mods_o[scs1a_pkg::M_RCTRL] = !rel;
        end else begin
          mods_o[scs1a_pkg::M_LCTRL] = !rel;
        end
      end
      scs1a_pkg::CODE_ALT: begin
        if (ext_i) begin
          mods_o[scs1a_pkg::M_RALT] = !rel;
        end else begin
          mods_o[scs1a_pkg::M_LALT] = !rel;
        end
      end
      scs1a_pkg::CODE_CAPS: begin
        mods_o[scs1a_pkg::M_CAPS] = mods_i[scs1a_pkg::M_CAPS] ^ !rel;
        led = 1'b1;
      end
      scs1a_pkg::CODE_NUM: begin
        mods_o[scs1a_pkg::M_NUM] = mods_i[scs1a_pkg::M_NUM] ^ !rel;
        led = 1'b1;
      end
      scs1a_pkg::CODE_SCROLL: begin
        mods_o[scs1a_pkg::M_SCROLL] = mods_i[scs1a_pkg::M_SCROLL] ^ !rel;
        led = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    base  = scs1a_pkg::PLAIN_MAP[idx];
    upper = scs1a_pkg::UPPER_MAP[idx];
    shift = mods_i[scs1a_pkg::M_LSHIFT] | mods_i[scs1a_pkg::M_RSHIFT];
    if (mods_i[scs1a_pkg::M_CAPS] &&
        (base inside {[scs1a_pkg::CHAR_LOW_A:scs1a_pkg::CHAR_LOW_Z],
                      [scs1a_pkg::CHAR_UP_A:scs1a_pkg::CHAR_UP_Z]})) begin
      shift = !shift;
    end
    if (rel || ext_i || (code > scs1a_pkg::CODE_LAST_CHAR)) begin
      ascii = 7'h00;
    end else if (shift && (upper != 7'h00)) begin
      ascii = upper;
    end else begin
      ascii = base;
    end
  end

  always_comb begin
    event_o.key_code          = code;
    event_o.is_release        = rel;
    event_o.ext_flag          = ext_i;
    event_o.modifier_snapshot = mods_i;
    event_o.ascii_char        = ascii;
    event_o.led_write         = led;
    event_o.led_value         = {mods_o[scs1a_pkg::M_CAPS], mods_o[scs1a_pkg::M_NUM],
                                 mods_o[scs1a_pkg::M_SCROLL]};
  end

endmodule
